FILE: design/eft_pkg.sv
package eft_pkg;

  // Register map, word index on the configuration port
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;
  localparam logic [REG_IDX_W-1:0] REG_FRAMING_ENABLE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STATION_ADDRESS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASTER_MODE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAD_ENABLE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_CODE      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STOP_CODE       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE     = 3'd6;

  localparam logic       RST_FRAMING_ENABLE  = 1'b0;
  localparam logic [7:0] RST_STATION_ADDRESS = 8'd0;
  localparam logic       RST_MASTER_MODE     = 1'b1;
  localparam logic       RST_PAD_ENABLE      = 1'b0;
  localparam logic [7:0] RST_START_CODE      = 8'd250;
  localparam logic [7:0] RST_STOP_CODE       = 8'd251;
  localparam logic [7:0] RST_ESCAPE_CODE     = 8'd252;

  // Results per input beat are capped
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       first;
    logic       last;
  } eft_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } eft_out_t;

  typedef struct packed {
    logic       framing_enable;
    logic [7:0] station_address;
    logic       master_mode;
    logic       pad_enable;
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] escape_code;
  } eft_cfg_t;

  // One classified beat: which parts of the line sequence to send
  typedef struct packed {
    logic       raw;
    logic       do_start;
    logic       do_addr;
    logic       do_data;
    logic       do_close;
    logic [7:0] data;
    logic [7:0] chk;
    logic [7:0] pad_n;
  } eft_desc_t;

  function automatic logic is_special(eft_cfg_t cfg, logic [7:0] b);
    return (b == cfg.start_code) || (b == cfg.stop_code) || (b == cfg.escape_code);
  endfunction

endpackage

FILE: design/eft_queue.sv
module eft_queue
  import eft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  eft_desc_t push_desc,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output eft_desc_t head
);

  eft_desc_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/eft_front.sv
module eft_front
  import eft_pkg::*;
#(
  parameter int BODY_TARGET = 30
) (
  input  logic      clk,
  input  logic      rst_n,
  input  eft_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  eft_in_t   in_data,
  input  logic      q_full,
  output logic      push,
  output eft_desc_t push_desc
);

  localparam logic [9:0] TGT_ESC   = 10'(BODY_TARGET - 2);
  localparam logic [9:0] TGT_PLAIN = 10'(BODY_TARGET - 1);

  logic [7:0] chk_r, chk_nxt;
  logic [7:0] bc_r, bc_nxt;

  logic       accept;
  logic       chk_spec;
  logic       zero_two;
  logic [9:0] base_bc;
  logic [9:0] addr_len;
  logic [9:0] data_len;
  logic [9:0] s1, s2, s3, tgt, pad10, bc_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    base_bc  = in_data.first ? 10'd0 : {2'b00, bc_r};
    addr_len = !in_data.first ? 10'd0 :
               (is_special(cfg, cfg.station_address) ? 10'd2 : 10'd1);
    data_len = !in_data.has_data ? 10'd0 :
               (is_special(cfg, in_data.data_byte) ? 10'd2 : 10'd1);
    s1       = base_bc + addr_len + data_len;

    chk_nxt  = (in_data.first ? cfg.station_address : chk_r) ^
               (in_data.has_data ? in_data.data_byte : 8'h00);
    chk_spec = is_special(cfg, chk_nxt);
    zero_two = is_special(cfg, 8'h00);
    tgt      = chk_spec ? TGT_ESC : TGT_PLAIN;

    // zeros that still fit before the checksum; raw beats never pad
    if (cfg.framing_enable && cfg.pad_enable && in_data.last && (s1 <= tgt)) begin
      pad10 = zero_two ? ((tgt - s1) >> 1) : (tgt - s1);
    end else begin
      pad10 = 10'd0;
    end
    s2     = s1 + (zero_two ? (pad10 << 1) : pad10);
    s3     = s2 + (chk_spec ? 10'd2 : 10'd1);
    bc_end = in_data.last ? s3 : s1;
    bc_nxt = (bc_end > 10'd255) ? 8'd255 : bc_end[7:0];
  end

  always_comb begin
    push_desc.raw      = !cfg.framing_enable;
    push_desc.do_start = cfg.framing_enable && in_data.first && cfg.master_mode;
    push_desc.do_addr  = cfg.framing_enable && in_data.first;
    push_desc.do_data  = in_data.has_data;
    push_desc.do_close = cfg.framing_enable && in_data.last;
    push_desc.data     = in_data.data_byte;
    push_desc.chk      = chk_nxt;
    push_desc.pad_n    = pad10[7:0];
    // drop beats that put nothing on the line
    push = accept && (cfg.framing_enable
                      ? (in_data.first || in_data.has_data || in_data.last)
                      : in_data.has_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= '0;
      bc_r  <= '0;
    end else if (accept && cfg.framing_enable) begin
      chk_r <= chk_nxt;
      bc_r  <= bc_nxt;
    end
  end

endmodule

FILE: design/eft_back.sv
module eft_back
  import eft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  eft_cfg_t  cfg,
  input  logic      q_valid,
  input  eft_desc_t q_desc,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output eft_out_t  out_data
);

  localparam int NUM_PHASES = 6;
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_PAD   = 3'd3;
  localparam logic [2:0] PH_CHK   = 3'd4;
  localparam logic [2:0] PH_STOP  = 3'd5;

  function automatic logic [NUM_PHASES-1:0] phases_of(eft_desc_t d);
    logic [NUM_PHASES-1:0] en;
    en           = '0;
    en[PH_START] = d.do_start;
    en[PH_ADDR]  = d.do_addr;
    en[PH_DATA]  = d.do_data;
    en[PH_PAD]   = (d.pad_n != 8'd0);
    en[PH_CHK]   = d.do_close;
    en[PH_STOP]  = d.do_close;
    return en;
  endfunction

  // {found, phase}: lowest enabled phase at or above lo
  function automatic logic [3:0] find_from(logic [NUM_PHASES-1:0] en, int lo);
    logic [3:0] res;
    res = 4'd0;
    for (int i = NUM_PHASES - 1; i >= 0; i--) begin
      if (i >= lo && en[i]) begin
        res = {1'b1, 3'(i)};
      end
    end
    return res;
  endfunction

  eft_desc_t        desc_r;
  logic             busy_r;
  logic [2:0]       ph_r;
  logic             esc_sec_r;
  logic [7:0]       pad_left_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  eft_out_t         out_data_r;

  logic [NUM_PHASES-1:0] en;
  logic [3:0]  first_ph;
  logic [3:0]  next_ph;
  logic [7:0]  cur_val;
  logic        escapable;
  logic        two;
  logic [7:0]  byte_v;
  logic        elem_done;
  logic        phase_done;
  logic        final_v;
  logic        step;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    en       = phases_of(desc_r);
    first_ph = find_from(phases_of(q_desc), 0);
    next_ph  = find_from(en, int'(ph_r) + 1);

    case (ph_r)
      PH_START: cur_val = cfg.start_code;
      PH_ADDR:  cur_val = cfg.station_address;
      PH_DATA:  cur_val = desc_r.data;
      PH_PAD:   cur_val = 8'h00;
      PH_CHK:   cur_val = desc_r.chk;
      PH_STOP:  cur_val = cfg.stop_code;
      default:  cur_val = 8'h00;
    endcase

    escapable  = (ph_r == PH_ADDR) || (ph_r == PH_PAD) || (ph_r == PH_CHK) ||
                 ((ph_r == PH_DATA) && !desc_r.raw);
    two        = escapable && is_special(cfg, cur_val);
    byte_v     = esc_sec_r ? (cur_val - cfg.start_code) :
                 (two ? cfg.escape_code : cur_val);
    elem_done  = !two || esc_sec_r;
    phase_done = elem_done && ((ph_r != PH_PAD) || (pad_left_r == 8'd1));
    final_v    = (phase_done && !next_ph[3]) || (cnt_r == CNT_W'(MAX_RESULTS - 1));

    step = busy_r && (!out_valid_r || out_ready);
    pop  = !busy_r && q_valid;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= q_desc;
    end
    if (step) begin
      out_data_r.out_byte <= byte_v;
      out_data_r.run_last <= final_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= PH_START;
      esc_sec_r   <= 1'b0;
      pad_left_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r     <= 1'b1;
        ph_r       <= first_ph[2:0];
        esc_sec_r  <= 1'b0;
        pad_left_r <= q_desc.pad_n;
        cnt_r      <= '0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_r + 1'b1;
        if (final_v) begin
          busy_r <= 1'b0;
        end else if (elem_done) begin
          esc_sec_r <= 1'b0;
          if (phase_done) begin
            ph_r       <= next_ph[2:0];
            pad_left_r <= desc_r.pad_n;
          end else begin
            // another pad zero
            pad_left_r <= pad_left_r - 1'b1;
          end
        end else begin
          esc_sec_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: design/escaped_frame_transmitter.sv
// Channel  | Ports                               | Beat
// ---------+-------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data         | one payload byte with flags
// result   | out_valid, out_ready, out_data      | one line byte, run_last flag
// config   | psel, penable, pwrite, paddr, ...   | one register write or read
//
// The back sequencer loads a beat from the queue, then sends its line bytes one per
// cycle from the output register while out_ready does not stall it.
// The front classifies an input beat combinationally and takes a new one while the
// two-entry queue has room. Reset (rst_n low, synchronous) clears the checksum,
// body count, queue and sequencer and loads the register reset values.
// A stalled out_ready holds the sequencer; in_ready drops only when the queue is full.
module escaped_frame_transmitter
  import eft_pkg::*;
#(
  parameter int BODY_TARGET = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  eft_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eft_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       framing_enable_r;
  logic [7:0] station_address_r;
  logic       master_mode_r;
  logic       pad_enable_r;
  logic [7:0] start_code_r;
  logic [7:0] stop_code_r;
  logic [7:0] escape_code_r;

  eft_cfg_t              cfg;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  logic      push;
  eft_desc_t push_desc;
  logic      pop;
  logic      q_full;
  logic      q_valid;
  eft_desc_t q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg.framing_enable  = framing_enable_r;
    cfg.station_address = station_address_r;
    cfg.master_mode     = master_mode_r;
    cfg.pad_enable      = pad_enable_r;
    cfg.start_code      = start_code_r;
    cfg.stop_code       = stop_code_r;
    cfg.escape_code     = escape_code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_enable_r  <= RST_FRAMING_ENABLE;
      station_address_r <= RST_STATION_ADDRESS;
      master_mode_r     <= RST_MASTER_MODE;
      pad_enable_r      <= RST_PAD_ENABLE;
      start_code_r      <= RST_START_CODE;
      stop_code_r       <= RST_STOP_CODE;
      escape_code_r     <= RST_ESCAPE_CODE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAMING_ENABLE:  framing_enable_r  <= pwdata[0];
        REG_STATION_ADDRESS: station_address_r <= pwdata[7:0];
        REG_MASTER_MODE:     master_mode_r     <= pwdata[0];
        REG_PAD_ENABLE:      pad_enable_r      <= pwdata[0];
        REG_START_CODE:      start_code_r      <= pwdata[7:0];
        REG_STOP_CODE:       stop_code_r       <= pwdata[7:0];
        REG_ESCAPE_CODE:     escape_code_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAMING_ENABLE:  prdata = {31'd0, framing_enable_r};
      REG_STATION_ADDRESS: prdata = {24'd0, station_address_r};
      REG_MASTER_MODE:     prdata = {31'd0, master_mode_r};
      REG_PAD_ENABLE:      prdata = {31'd0, pad_enable_r};
      REG_START_CODE:      prdata = {24'd0, start_code_r};
      REG_STOP_CODE:       prdata = {24'd0, stop_code_r};
      REG_ESCAPE_CODE:     prdata = {24'd0, escape_code_r};
      default:             prdata = 32'd0;
    endcase
  end

  eft_front #(
    .BODY_TARGET(BODY_TARGET)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_desc(push_desc)
  );

  eft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head)
  );

  eft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_desc   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import eft_pkg::*;

  localparam int BODY_TARGET     = 30;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 10;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [7:0]             reg_val;
    eft_in_t                beat;
    int                     n_typed;
    logic [0:3][7:0]        typed;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  eft_in_t            in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  eft_out_t           out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow of the block's registers and framing state
  eft_cfg_t   sh_cfg;
  logic [7:0] chk_acc;
  int         body_len;

  logic [7:0] line_buf[$];
  eft_out_t   line_exp[$];
  dir_row_t   dir_rows[$];

  int              typed_n;
  logic [0:3][7:0] typed_bytes;
  int              src_pct;
  int              snk_pct;
  int              err_cnt;
  int              in_cnt;
  int              out_cnt;
  int              cfg_cnt;
  int              stall_cycles;

  escaped_frame_transmitter #(
    .BODY_TARGET(BODY_TARGET)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_pct);
  end

  function automatic logic is_delim(logic [7:0] b);
    return (b == sh_cfg.start_code) || (b == sh_cfg.stop_code) || (b == sh_cfg.escape_code);
  endfunction

  function automatic void grow_body(int k);
    body_len = (body_len + k > 255) ? 255 : body_len + k;
  endfunction

  function automatic void put_line(logic [7:0] b);
    if (line_buf.size() < MAX_RESULTS) line_buf.push_back(b);
  endfunction

  function automatic void put_escaped(logic [7:0] b);
    if (is_delim(b)) begin
      put_line(sh_cfg.escape_code);
      put_line(b - sh_cfg.start_code);
      grow_body(2);
    end else begin
      put_line(b);
      grow_body(1);
    end
  endfunction

  // Fill line_buf with the line bytes one input beat produces
  function automatic void predict_line(eft_in_t b);
    int target;
    int zlen;
    line_buf.delete();
    if (!sh_cfg.framing_enable) begin
      if (b.has_data) put_line(b.data_byte);
    end else begin
      if (b.first) begin
        body_len = 0;
        chk_acc  = sh_cfg.station_address;
        if (sh_cfg.master_mode) put_line(sh_cfg.start_code);
        put_escaped(sh_cfg.station_address);
      end
      if (b.has_data) begin
        chk_acc ^= b.data_byte;
        put_escaped(b.data_byte);
      end
      if (b.last) begin
        if (sh_cfg.pad_enable) begin
          target = is_delim(chk_acc) ? BODY_TARGET - 2 : BODY_TARGET - 1;
          zlen   = is_delim(8'h00) ? 2 : 1;
          while (body_len + zlen <= target) put_escaped(8'h00);
        end
        put_escaped(chk_acc);
        put_line(sh_cfg.stop_code);
      end
    end
  endfunction

  function automatic logic [31:0] cfg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_FRAMING_ENABLE:  return {31'd0, sh_cfg.framing_enable};
      REG_STATION_ADDRESS: return {24'd0, sh_cfg.station_address};
      REG_MASTER_MODE:     return {31'd0, sh_cfg.master_mode};
      REG_PAD_ENABLE:      return {31'd0, sh_cfg.pad_enable};
      REG_START_CODE:      return {24'd0, sh_cfg.start_code};
      REG_STOP_CODE:       return {24'd0, sh_cfg.stop_code};
      REG_ESCAPE_CODE:     return {24'd0, sh_cfg.escape_code};
      default:             return 32'd0;
    endcase
  endfunction

  always @(posedge clk) begin : line_mon
    eft_out_t want;
    eft_out_t r;
    logic     moved;
    int       i;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        out_cnt++;
        if (line_exp.size() == 0) begin
          $error("unexpected line byte %h run_last %b", out_data.out_byte, out_data.run_last);
          err_cnt++;
        end else begin
          want = line_exp.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
            err_cnt++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, out_data.run_last);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        in_cnt++;
        predict_line(in_data);
        // typed-in rows replace the computed bytes, state still advances
        if (typed_n >= 0) begin
          line_buf.delete();
          for (i = 0; i < typed_n; i++) line_buf.push_back(typed_bytes[i]);
        end
        for (i = 0; i < line_buf.size(); i++) begin
          r.out_byte = line_buf[i];
          r.run_last = (i == line_buf.size() - 1);
          line_exp.push_back(r);
        end
      end
      if (psel && penable && pready) moved = 1'b1;
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  task automatic set_idle(idle_mode_e m);
    case (m)
      IDLE_NONE: begin src_pct = 0;  snk_pct = 0;  end
      IDLE_SRC:  begin src_pct = 49; snk_pct = 0;  end
      IDLE_SNK:  begin src_pct = 0;  snk_pct = 49; end
      default:   begin src_pct = 34; snk_pct = 34; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(eft_in_t b);
    while ($urandom_range(99) < src_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (line_exp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic read_reg(logic [REG_IDX_W-1:0] idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== cfg_value(idx)) begin
      $error("register %0d: expected %h, actual %h", idx, cfg_value(idx), prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FRAMING_ENABLE:  sh_cfg.framing_enable  = val[0];
      REG_STATION_ADDRESS: sh_cfg.station_address = val[7:0];
      REG_MASTER_MODE:     sh_cfg.master_mode     = val[0];
      REG_PAD_ENABLE:      sh_cfg.pad_enable      = val[0];
      REG_START_CODE:      sh_cfg.start_code      = val[7:0];
      REG_STOP_CODE:       sh_cfg.stop_code       = val[7:0];
      REG_ESCAPE_CODE:     sh_cfg.escape_code     = val[7:0];
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk);
    read_reg(idx);
  endtask

  function automatic void row_cfg(logic [REG_IDX_W-1:0] idx, logic [7:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.beat    = '0;
    r.n_typed = -1;
    r.typed   = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_beat(logic [7:0] d, logic h, logic f, logic l,
                                   int n, logic [31:0] t);
    dir_row_t r;
    r.kind           = ROW_BEAT;
    r.reg_idx        = '0;
    r.reg_val        = '0;
    r.beat.data_byte = d;
    r.beat.has_data  = h;
    r.beat.first     = f;
    r.beat.last      = l;
    r.n_typed        = n;
    r.typed          = t;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return sh_cfg.start_code;
    if (r < 22) return sh_cfg.stop_code;
    if (r < 32) return sh_cfg.escape_code;
    if (r < 36) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic rand_settings(int p);
    logic [7:0] sc;
    logic [7:0] tc;
    logic [7:0] ec;
    logic [7:0] ad;
    case ((p / 2) % 4)
      0: begin sc = 8'd250; tc = 8'd251; ec = 8'd252; end
      1: begin
        sc = 8'($urandom_range(255));
        tc = 8'($urandom_range(255));
        ec = 8'($urandom_range(255));
      end
      2: begin sc = 8'h00; tc = 8'hFF; ec = 8'h01; end
      default: begin sc = 8'hFF; tc = 8'h00; ec = 8'($urandom_range(255)); end
    endcase
    case ($urandom_range(3))
      0:       ad = 8'($urandom_range(255));
      1:       ad = ec;
      2:       ad = 8'h00;
      default: ad = 8'hFF;
    endcase
    write_reg(REG_FRAMING_ENABLE, (p == 5) ? 32'd0 : 32'd1);
    write_reg(REG_STATION_ADDRESS, {24'd0, ad});
    write_reg(REG_MASTER_MODE, 32'($urandom_range(1)));
    write_reg(REG_PAD_ENABLE, (p % 3 != 0) ? 32'd1 : 32'd0);
    write_reg(REG_START_CODE, {24'd0, sc});
    write_reg(REG_STOP_CODE, {24'd0, tc});
    write_reg(REG_ESCAPE_CODE, {24'd0, ec});
  endtask

  // Mostly whole frames with random content, some noise and broken frames
  task automatic run_random(int n_beats);
    eft_in_t b;
    int      sent;
    int      len;
    int      bk;
    int      j;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(99) < 12) begin
        b = eft_in_t'($urandom_range(2047));
        send_beat(b);
        sent++;
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(18, 10);
        // 1 drops the opening flag, 2 drops the closing flag
        bk  = ($urandom_range(99) < 10) ? $urandom_range(2, 1) : 0;
        if (len == 0) begin
          b.data_byte = pick_byte();
          b.has_data  = 1'b0;
          b.first     = 1'b1;
          b.last      = 1'b1;
          send_beat(b);
          sent++;
        end else begin
          for (j = 0; j < len; j++) begin
            b.data_byte = pick_byte();
            b.has_data  = ($urandom_range(99) >= 8);
            b.first     = (j == 0) && (bk != 1);
            b.last      = (j == len - 1) && (bk != 2);
            send_beat(b);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    dir_row_t row;
    int       k;
    int       p;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    typed_n      = -1;
    typed_bytes  = '0;
    err_cnt      = 0;
    in_cnt       = 0;
    out_cnt      = 0;
    cfg_cnt      = 0;
    stall_cycles = 0;
    chk_acc      = 8'h00;
    body_len     = 0;
    sh_cfg.framing_enable  = RST_FRAMING_ENABLE;
    sh_cfg.station_address = RST_STATION_ADDRESS;
    sh_cfg.master_mode     = RST_MASTER_MODE;
    sh_cfg.pad_enable      = RST_PAD_ENABLE;
    sh_cfg.start_code      = RST_START_CODE;
    sh_cfg.stop_code       = RST_STOP_CODE;
    sh_cfg.escape_code     = RST_ESCAPE_CODE;
    set_idle(IDLE_NONE);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (k = 0; k <= int'(REG_ESCAPE_CODE); k++) read_reg(k[REG_IDX_W-1:0]);

    // pass-through after reset
    row_beat(8'h00, 1, 0, 0, 1, 32'h00000000);
    row_beat(8'hFF, 1, 1, 1, 1, 32'hFF000000);
    row_beat(8'h5A, 0, 1, 1, 0, 32'h00000000);
    // framing with reset codes: open, each escape, close, empty frame
    row_cfg(REG_FRAMING_ENABLE, 8'd1);
    row_beat(8'h11, 1, 1, 0, 3, 32'hFA001100);
    row_beat(8'hFA, 1, 0, 0, 2, 32'hFC000000);
    row_beat(8'hFB, 1, 0, 0, 2, 32'hFC010000);
    row_beat(8'hFC, 1, 0, 0, 2, 32'hFC020000);
    row_beat(8'h00, 0, 0, 1, 2, 32'hECFB0000);
    row_beat(8'h00, 0, 1, 1, 4, 32'hFA0000FB);
    row_beat(8'hFF, 1, 1, 1, -1, 32'h0);
    // slave, padding, address that needs escaping
    row_cfg(REG_STATION_ADDRESS, 8'hFA);
    row_cfg(REG_MASTER_MODE, 8'd0);
    row_cfg(REG_PAD_ENABLE, 8'd1);
    row_beat(8'h42, 1, 1, 1, -1, 32'h0);
    row_beat(8'h00, 0, 1, 1, -1, 32'h0);
    row_beat(8'h00, 1, 1, 0, -1, 32'h0);
    row_beat(8'hFB, 1, 0, 0, -1, 32'h0);
    row_beat(8'hFF, 1, 0, 1, -1, 32'h0);
    // zero as a delimiter: pad zeros take two bytes
    row_cfg(REG_START_CODE, 8'h00);
    row_cfg(REG_STOP_CODE, 8'hFF);
    row_cfg(REG_ESCAPE_CODE, 8'h80);
    row_beat(8'h00, 1, 1, 0, -1, 32'h0);
    row_beat(8'hFF, 1, 0, 0, -1, 32'h0);
    row_beat(8'h80, 1, 0, 1, -1, 32'h0);
    // beats with no open frame
    row_beat(8'h00, 0, 0, 1, -1, 32'h0);
    row_beat(8'h33, 1, 0, 0, -1, 32'h0);
    // raw mode ignores flags and odd codes
    row_cfg(REG_FRAMING_ENABLE, 8'd0);
    row_beat(8'h80, 1, 1, 1, 1, 32'h80000000);
    row_beat(8'h00, 0, 0, 0, 0, 32'h00000000);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        in_valid = 1'b0;
        wait_drain();
        write_reg(row.reg_idx, {24'd0, row.reg_val});
      end else begin
        typed_n     = row.n_typed;
        typed_bytes = row.typed;
        send_beat(row.beat);
      end
    end
    typed_n = -1;

    for (p = 0; p < RANDOM_PHASES; p++) begin
      in_valid = 1'b0;
      wait_drain();
      set_idle(idle_mode_e'(p % 4));
      rand_settings(p);
      run_random(BEATS_PER_PHASE);
    end
    in_valid = 1'b0;
    wait_drain();

    if (line_exp.size() != 0) begin
      $error("%0d line bytes never arrived", line_exp.size());
      err_cnt++;
    end
    $display("Covered %0d input beats, %0d line bytes, %0d register writes", in_cnt, out_cnt,
             cfg_cnt);
    $display("across raw and framed modes, padding, and delimiters at 0 and 255.");
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
